/* rtl/motor_command_parser_macros.svh */
// Assertion macros used by the motor command parser core (mcp_parser_core).
// Expects clk and rst_n to be visible in the module that uses them.
`ifndef MOTOR_COMMAND_PARSER_MACROS_SVH
`define MOTOR_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define MCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define MCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mcp_pkg.sv */
// Shared types and constants for the motor command parser.
// No dependencies; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps
`default_nettype none

package mcp_pkg;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_LINK = 1'b1;

    localparam logic [7:0] BYTE_ZERO  = 8'd48;
    localparam logic [7:0] BYTE_ONE   = 8'd49;
    localparam logic [7:0] BYTE_TWO   = 8'd50;
    localparam logic [7:0] BYTE_THREE = 8'd51;
    localparam logic [7:0] BYTE_FOUR  = 8'd52;
    localparam logic [7:0] BYTE_FIVE  = 8'd53;

    // three digits of -48..207 each stay within -5328..22977
    localparam int SPEED_W = 16;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd255;

    typedef logic signed [SPEED_W-1:0] speed_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       link_online;
    } cmd_t;

    typedef struct packed {
        logic       right_forward;
        logic       right_reverse;
        logic       left_forward;
        logic       left_reverse;
        logic [7:0] duty_right;
        logic [7:0] duty_left;
        logic       receiving_light;
        logic       online_light;
    } status_t;

endpackage

`default_nettype wire

/* rtl/mcp_cmd_if.sv */
// Valid/ready channel carrying one command word (serial byte or link event).
// Depends on mcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mcp_cmd_if;
    import mcp_pkg::*;

    logic valid;
    logic ready;
    cmd_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/mcp_status_if.sv */
// Valid/ready channel carrying one status word (pins, duties, lights).
// Depends on mcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mcp_status_if;
    import mcp_pkg::*;

    logic    valid;
    logic    ready;
    status_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/mcp_input_stage.sv */
// Input register for command words; full throughput, stalls only when downstream does.
// Depends on mcp_pkg and mcp_cmd_if.
`timescale 1ns / 1ps
`default_nettype none

module mcp_input_stage
    import mcp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcp_cmd_if.sink     up,
    mcp_cmd_if.source   down
);

    logic valid_reg;
    logic valid_next;
    cmd_t item_reg;
    cmd_t item_next;
    logic up_fire;

    assign up.ready   = !valid_reg || down.ready;
    assign up_fire    = up.valid && up.ready;
    assign down.valid = valid_reg;
    assign down.item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_fire)
        begin
            valid_next = 1'b1;
            item_next  = up.item;
        end
        else if (down.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            item_reg  <= item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mcp_parser_core.sv */
// Command decoder state machine with the motor pin, duty and status word registers.
// Depends on mcp_pkg, mcp_cmd_if, mcp_status_if and motor_command_parser_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "motor_command_parser_macros.svh"

module mcp_parser_core
    import mcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mcp_cmd_if.sink       cmd,
    mcp_status_if.source  status
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RIGHT,
        PH_LEFT,
        PH_S1_D0,
        PH_S1_D1,
        PH_S1_D2,
        PH_S2_D0,
        PH_S2_D1,
        PH_S2_D2,
        PH_CONFIRM
    } phase_t;

    phase_t     phase_reg,      phase_next;
    logic [7:0] right_code_reg, right_code_next;
    logic [7:0] left_code_reg,  left_code_next;
    speed_t     speed_one_reg,  speed_one_next;
    speed_t     speed_two_reg,  speed_two_next;
    logic       speed_bad_reg,  speed_bad_next;
    logic [3:0] pins_reg,       pins_next;      // {lr, lf, rr, rf}
    logic [7:0] duty_r_reg,     duty_r_next;
    logic [7:0] duty_l_reg,     duty_l_next;
    logic       online_reg,     online_next;
    logic       res_valid_reg,  res_valid_next;
    status_t    res_item_reg,   res_item_next;

    logic   fire;
    speed_t digit;
    speed_t acc_one;
    speed_t acc_two;

    function automatic logic speed_ok(input speed_t s);
        return (s >= 0) && (s <= SPEED_MAX);
    endfunction

    function automatic logic [3:0] apply_dirs(input logic [3:0] pins,
                                              input logic [7:0] rcode,
                                              input logic [7:0] lcode);
        logic [3:0] p;
        p = pins;
        if (rcode == BYTE_ONE)
        begin
            p[1:0] = 2'b01;
        end
        else if (rcode == BYTE_TWO)
        begin
            p[1:0] = 2'b10;
        end
        if (lcode == BYTE_THREE)
        begin
            p[3:2] = 2'b01;
        end
        else if (lcode == BYTE_FOUR)
        begin
            p[3:2] = 2'b10;
        end
        return p;
    endfunction

    assign cmd.ready    = !res_valid_reg || status.ready;
    assign fire         = cmd.valid && cmd.ready;
    assign status.valid = res_valid_reg;
    assign status.item  = res_item_reg;

    assign digit   = speed_t'({{(SPEED_W-8){1'b0}}, cmd.item.rx_byte})
                   - speed_t'({{(SPEED_W-8){1'b0}}, BYTE_ZERO});
    assign acc_one = (speed_one_reg <<< 3) + (speed_one_reg <<< 1) + digit;
    assign acc_two = (speed_two_reg <<< 3) + (speed_two_reg <<< 1) + digit;

    always_comb
    begin
        phase_next      = phase_reg;
        right_code_next = right_code_reg;
        left_code_next  = left_code_reg;
        speed_one_next  = speed_one_reg;
        speed_two_next  = speed_two_reg;
        speed_bad_next  = speed_bad_reg;
        pins_next       = pins_reg;
        duty_r_next     = duty_r_reg;
        duty_l_next     = duty_l_reg;
        online_next     = online_reg;

        if (fire)
        begin
            if (cmd.item.action == ACT_LINK)
            begin
                online_next = cmd.item.link_online;
                if ((phase_reg == PH_IDLE) && !cmd.item.link_online)
                begin
                    pins_next = '0;
                end
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_IDLE:
                    begin
                        if (online_reg && (cmd.item.rx_byte == BYTE_ONE))
                        begin
                            phase_next = PH_RIGHT;
                        end
                    end
                    PH_RIGHT:
                    begin
                        right_code_next = cmd.item.rx_byte;
                        phase_next      = PH_LEFT;
                    end
                    PH_LEFT:
                    begin
                        left_code_next = cmd.item.rx_byte;
                        if ((right_code_reg > BYTE_FIVE) || (cmd.item.rx_byte > BYTE_FIVE))
                        begin
                            phase_next = PH_IDLE;
                            if (!online_reg)
                            begin
                                pins_next = '0;
                            end
                        end
                        else if ((right_code_reg == BYTE_FIVE) ||
                                 (cmd.item.rx_byte == BYTE_FIVE))
                        begin
                            phase_next = PH_IDLE;
                            pins_next  = '0;
                        end
                        else
                        begin
                            speed_one_next = '0;
                            speed_two_next = '0;
                            speed_bad_next = 1'b0;
                            phase_next     = PH_S1_D0;
                        end
                    end
                    PH_S1_D0, PH_S1_D1:
                    begin
                        speed_one_next = acc_one;
                        phase_next     = phase_t'(phase_reg + 4'd1);
                    end
                    PH_S1_D2:
                    begin
                        speed_one_next = acc_one;
                        speed_bad_next = !speed_ok(acc_one);
                        phase_next     = PH_S2_D0;
                    end
                    PH_S2_D0, PH_S2_D1:
                    begin
                        speed_two_next = acc_two;
                        phase_next     = phase_t'(phase_reg + 4'd1);
                    end
                    PH_S2_D2:
                    begin
                        speed_two_next = acc_two;
                        if (speed_bad_reg || !speed_ok(acc_two))
                        begin
                            phase_next = PH_IDLE;
                            if (!online_reg)
                            begin
                                pins_next = '0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_CONFIRM;
                        end
                    end
                    PH_CONFIRM:
                    begin
                        phase_next = PH_IDLE;
                        if (cmd.item.rx_byte == BYTE_ONE)
                        begin
                            pins_next   = apply_dirs(pins_reg, right_code_reg, left_code_reg);
                            duty_r_next = speed_one_reg[7:0];
                            duty_l_next = speed_two_reg[7:0];
                        end
                        if (!online_reg)
                        begin
                            pins_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_item_next                 = res_item_reg;
        res_valid_next                = res_valid_reg;
        if (fire)
        begin
            res_valid_next                = 1'b1;
            res_item_next.right_forward   = pins_next[0];
            res_item_next.right_reverse   = pins_next[1];
            res_item_next.left_forward    = pins_next[2];
            res_item_next.left_reverse    = pins_next[3];
            res_item_next.duty_right      = duty_r_next;
            res_item_next.duty_left       = duty_l_next;
            res_item_next.receiving_light = (phase_next != PH_IDLE);
            res_item_next.online_light    = online_next;
        end
        else if (status.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            right_code_reg <= '0;
            left_code_reg  <= '0;
            speed_one_reg  <= '0;
            speed_two_reg  <= '0;
            speed_bad_reg  <= 1'b0;
            pins_reg       <= '0;
            duty_r_reg     <= '0;
            duty_l_reg     <= '0;
            online_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_item_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            right_code_reg <= right_code_next;
            left_code_reg  <= left_code_next;
            speed_one_reg  <= speed_one_next;
            speed_two_reg  <= speed_two_next;
            speed_bad_reg  <= speed_bad_next;
            pins_reg       <= pins_next;
            duty_r_reg     <= duty_r_next;
            duty_l_reg     <= duty_l_next;
            online_reg     <= online_next;
            res_valid_reg  <= res_valid_next;
            res_item_reg   <= res_item_next;
        end
    end

    `MCP_ASSERT_NOW(a_right_pins_exclusive, 1'b1, !(pins_reg[0] && pins_reg[1]), "right motor driven both ways")
    `MCP_ASSERT_NOW(a_left_pins_exclusive, 1'b1, !(pins_reg[2] && pins_reg[3]), "left motor driven both ways")
    `MCP_ASSERT_NOW(a_offline_idle_pins_off, (phase_reg == PH_IDLE) && !online_reg, pins_reg == 4'b0000, "pins active while offline and idle")
    `MCP_ASSERT_NEXT(a_duty_only_on_confirm, fire && (phase_reg != PH_CONFIRM), $stable(duty_r_reg) && $stable(duty_l_reg), "duty changed outside confirm")
    `MCP_ASSERT_NEXT(a_link_keeps_phase, fire && (cmd.item.action == ACT_LINK), $stable(phase_reg), "link event moved the parser")
    `MCP_ASSERT_NEXT(a_bad_speed_ends, fire && (cmd.item.action == ACT_BYTE) && (phase_reg == PH_S2_D2) && speed_bad_reg, phase_reg == PH_IDLE, "bad speed did not end command")

endmodule

`default_nettype wire

/* rtl/motor_command_parser.sv */
// Top level of the motor command parser: input register feeding the decoder core.
// Depends on mcp_pkg, mcp_cmd_if, mcp_status_if, mcp_input_stage and mcp_parser_core.
`timescale 1ns / 1ps
`default_nettype none

// Every word accepted on cmd (a serial byte or a link status event) yields exactly one
// word on status showing the motor pins, both duties and both lights after that word.
// A new word is taken every cycle; a word goes through the input register and then the
// status register before its status word is valid on status. cmd only
// stalls while a status word is held back by status.ready and the input register is full.

module motor_command_parser
    import mcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mcp_cmd_if.sink       cmd,
    mcp_status_if.source  status
);

    mcp_cmd_if staged ();

    mcp_input_stage u_input_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (cmd),
        .down  (staged)
    );

    mcp_parser_core u_parser_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (staged),
        .status (status)
    );

endmodule

`default_nettype wire

/* tb/sv/motor_command_parser_tb.sv */
// Self-checking testbench for motor_command_parser: serial command words in, status words out.
// Depends on mcp_pkg, mcp_cmd_if, mcp_status_if and the parser RTL; predicts every status word.
`timescale 1ns / 1ps

module motor_command_parser_tb;
    import mcp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RIGHT,
        ST_LEFT,
        ST_SPD1_HI,
        ST_SPD1_MID,
        ST_SPD1_LO,
        ST_SPD2_HI,
        ST_SPD2_MID,
        ST_SPD2_LO,
        ST_CONFIRM
    } parse_state_t;

    typedef struct {
        cmd_t word;
        bit   wait_idle;
    } pending_word_t;

    logic clk;
    logic rst_n;

    mcp_cmd_if    cmd_ch ();
    mcp_status_if status_ch ();

    motor_command_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .status (status_ch)
    );

    // predictor state
    parse_state_t cmd_phase;
    logic [7:0]   right_dir_byte;
    logic [7:0]   left_dir_byte;
    int           speed_a;
    int           speed_b;
    bit           speed_a_bad;
    logic [3:0]   motor_pins;
    logic [15:0]  duty_pair;
    bit           link_up;

    int n_applied;
    int n_stops;
    int n_dropped;
    int n_rejected;
    int n_unconfirmed;

    pending_word_t pending_words[$];
    status_t       awaited_status[$];

    int  errors;
    int  n_accepted;
    int  n_checked;
    bit  cmd_taken;
    bit  cmd_busy;
    bit  hold_status;
    bit  drain_next;
    bit  gen_online;
    int  gap_left;
    int  burst_left;
    int  ready_mode;
    int  ready_left;
    bit  ready_next;
    pending_word_t offer;

    function automatic void close_command();
        cmd_phase = ST_IDLE;
        if (!link_up)
            motor_pins = 4'b0000;
    endfunction

    function automatic status_t next_status(cmd_t w);
        status_t s;
        int      digit;
        digit = int'(w.rx_byte) - int'(BYTE_ZERO);
        if (w.action == ACT_LINK) begin
            link_up = w.link_online;
            if (cmd_phase == ST_IDLE && !link_up)
                motor_pins = 4'b0000;
        end
        else begin
            case (cmd_phase)
                ST_IDLE: begin
                    if (link_up && w.rx_byte == BYTE_ONE)
                        cmd_phase = ST_RIGHT;
                end
                ST_RIGHT: begin
                    right_dir_byte = w.rx_byte;
                    cmd_phase = ST_LEFT;
                end
                ST_LEFT: begin
                    left_dir_byte = w.rx_byte;
                    if (right_dir_byte > BYTE_FIVE || left_dir_byte > BYTE_FIVE) begin
                        n_dropped++;
                        close_command();
                    end
                    else if (right_dir_byte == BYTE_FIVE || left_dir_byte == BYTE_FIVE) begin
                        motor_pins = 4'b0000;
                        n_stops++;
                        close_command();
                    end
                    else begin
                        speed_a = 0;
                        speed_b = 0;
                        speed_a_bad = 1'b0;
                        cmd_phase = ST_SPD1_HI;
                    end
                end
                ST_SPD1_HI, ST_SPD1_MID, ST_SPD1_LO: begin
                    speed_a = speed_a * 10 + digit;
                    cmd_phase = parse_state_t'(cmd_phase + 1);
                    if (cmd_phase == ST_SPD2_HI)
                        speed_a_bad = (speed_a < 0 || speed_a > int'(SPEED_MAX));
                end
                ST_SPD2_HI, ST_SPD2_MID, ST_SPD2_LO: begin
                    speed_b = speed_b * 10 + digit;
                    cmd_phase = parse_state_t'(cmd_phase + 1);
                    if (cmd_phase == ST_CONFIRM &&
                        (speed_a_bad || speed_b < 0 || speed_b > int'(SPEED_MAX))) begin
                        n_rejected++;
                        close_command();
                    end
                end
                default: begin
                    if (w.rx_byte == BYTE_ONE) begin
                        if (right_dir_byte == BYTE_ONE)
                            motor_pins[1:0] = 2'b01;
                        else if (right_dir_byte == BYTE_TWO)
                            motor_pins[1:0] = 2'b10;
                        if (left_dir_byte == BYTE_THREE)
                            motor_pins[3:2] = 2'b01;
                        else if (left_dir_byte == BYTE_FOUR)
                            motor_pins[3:2] = 2'b10;
                        duty_pair = {speed_b[7:0], speed_a[7:0]};
                        n_applied++;
                    end
                    else begin
                        n_unconfirmed++;
                    end
                    close_command();
                end
            endcase
        end
        s.right_forward   = motor_pins[0];
        s.right_reverse   = motor_pins[1];
        s.left_forward    = motor_pins[2];
        s.left_reverse    = motor_pins[3];
        s.duty_right      = duty_pair[7:0];
        s.duty_left       = duty_pair[15:8];
        s.receiving_light = (cmd_phase != ST_IDLE);
        s.online_light    = link_up;
        return s;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            if (errors < 40)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // stimulus builders
    function automatic void push_word(cmd_t w);
        pending_word_t p;
        p.word = w;
        p.wait_idle = drain_next;
        drain_next = 1'b0;
        pending_words.push_back(p);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        cmd_t w;
        w.action = ACT_BYTE;
        w.rx_byte = b;
        w.link_online = 1'($urandom_range(0, 1));
        push_word(w);
    endfunction

    function automatic void push_link(bit up);
        cmd_t w;
        w.action = ACT_LINK;
        w.rx_byte = 8'($urandom_range(0, 255));
        w.link_online = up;
        gen_online = up;
        push_word(w);
    endfunction

    function automatic void push_speed(int v);
        push_byte(BYTE_ZERO + 8'(v / 100));
        push_byte(BYTE_ZERO + 8'((v / 10) % 10));
        push_byte(BYTE_ZERO + 8'(v % 10));
    endfunction

    function automatic logic [7:0] pick_dir(logic [7:0] fwd, logic [7:0] back);
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return fwd;
        else if (r < 16)
            return back;
        else if (r == 16)
            return BYTE_FIVE;
        else if (r == 17)
            return BYTE_ZERO + 8'($urandom_range(0, 9));
        else if (r == 18)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 53));
    endfunction

    function automatic void fill_speed(ref logic [7:0] seq[11], input int at);
        int r;
        int v;
        r = $urandom_range(0, 19);
        if (r < 17) begin
            if (r < 13)
                v = $urandom_range(0, 255);
            else if (r == 13)
                v = 255;
            else if (r == 14)
                v = 0;
            else
                v = $urandom_range(256, 999);
            seq[at]     = BYTE_ZERO + 8'(v / 100);
            seq[at + 1] = BYTE_ZERO + 8'((v / 10) % 10);
            seq[at + 2] = BYTE_ZERO + 8'(v % 10);
        end
        else begin
            for (int k = 0; k < 3; k++)
                seq[at + k] = (r == 18) ? BYTE_ZERO + 8'($urandom_range(0, 9))
                                        : 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void gen_command();
        logic [7:0] seq[11];
        int         cut;
        if (!gen_online && $urandom_range(0, 9) != 0)
            push_link(1'b1);
        seq[0] = BYTE_ONE;
        seq[1] = pick_dir(BYTE_ONE, BYTE_TWO);
        seq[2] = pick_dir(BYTE_THREE, BYTE_FOUR);
        fill_speed(seq, 3);
        fill_speed(seq, 6);
        seq[10] = ($urandom_range(0, 6) != 0) ? BYTE_ONE : 8'($urandom_range(0, 255));
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 10) : 11;
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(0, 29) == 0)
                push_link($urandom_range(0, 3) != 0);
            push_byte(seq[k]);
        end
    endfunction

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // sample side
    always @(posedge clk) begin
        status_t want;
        status_t got;
        cmd_taken = rst_n && cmd_ch.valid && cmd_ch.ready;
        if (cmd_taken) begin
            awaited_status.push_back(next_status(cmd_ch.item));
            n_accepted++;
        end
        if (rst_n && status_ch.valid && status_ch.ready) begin
            got = status_ch.item;
            if (awaited_status.size() == 0) begin
                $display("%0t: status word with none expected: %p", $time, got);
                errors++;
            end
            else begin
                want = awaited_status.pop_front();
                check_field("right_forward", want.right_forward, got.right_forward);
                check_field("right_reverse", want.right_reverse, got.right_reverse);
                check_field("left_forward", want.left_forward, got.left_forward);
                check_field("left_reverse", want.left_reverse, got.left_reverse);
                check_field("duty_right", want.duty_right, got.duty_right);
                check_field("duty_left", want.duty_left, got.duty_left);
                check_field("receiving_light", want.receiving_light, got.receiving_light);
                check_field("online_light", want.online_light, got.online_light);
                n_checked++;
            end
        end
    end

    // command sender: bursts and gaps
    always @(negedge clk) begin
        if (rst_n) begin
            if (cmd_busy && cmd_taken)
                cmd_busy = 1'b0;
            if (!cmd_busy) begin
                if (gap_left > 0 && !hold_status) begin
                    gap_left--;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].wait_idle && awaited_status.size() != 0)) begin
                    offer = pending_words.pop_front();
                    cmd_busy = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            cmd_ch.valid <= cmd_busy;
            cmd_ch.item  <= offer.word;
        end
    end

    // status receiver: stall pattern switches among four randomly chosen modes
    always @(negedge clk) begin
        if (rst_n) begin
            if (ready_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                ready_left = $urandom_range(20, 120);
            end
            else begin
                ready_left--;
            end
            case (ready_mode)
                0: ready_next = 1'b1;
                1: ready_next = ($urandom_range(0, 3) != 0);
                2: ready_next = ~ready_next;
                default: ready_next = ($urandom_range(0, 9) < 3);
            endcase
            status_ch.ready <= ready_next && !hold_status;
        end
    end

    // long receiver hold-off so the input side backs up
    initial begin
        hold_status = 1'b0;
        while (n_accepted < 700)
            @(posedge clk);
        hold_status = 1'b1;
        repeat (300) @(posedge clk);
        hold_status = 1'b0;
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    initial begin : run_control
        int guard;
        int pick;
        int next_drain;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.item = '0;
        status_ch.ready = 1'b0;
        cmd_phase = ST_IDLE;
        right_dir_byte = '0;
        left_dir_byte = '0;
        speed_a = 0;
        speed_b = 0;
        speed_a_bad = 1'b0;
        motor_pins = '0;
        duty_pair = '0;
        link_up = 1'b0;
        gen_online = 1'b0;

        // directed: idle byte while offline, stop, dropped code, full apply at the
        // extremes, then offline mid-command with an out-of-range second speed
        push_byte(BYTE_ONE);
        push_link(1'b1);
        push_byte(BYTE_ONE);
        push_byte(BYTE_FIVE);
        push_byte(BYTE_FOUR);
        push_byte(BYTE_ONE);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(BYTE_ONE);
        push_byte(BYTE_ONE);
        push_byte(BYTE_THREE);
        push_speed(255);
        push_speed(128);
        push_byte(BYTE_ONE);
        push_byte(BYTE_ONE);
        push_byte(BYTE_TWO);
        push_byte(BYTE_FOUR);
        push_speed(0);
        push_link(1'b0);
        push_speed(256);

        drain_next = 1'b1;
        next_drain = 500;
        while (pending_words.size() < 1950) begin
            if (pending_words.size() >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 500;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                gen_command();
            end
            else if (pick < 85) begin
                push_link($urandom_range(0, 3) != 0);
            end
            else begin
                repeat ($urandom_range(1, 4))
                    push_byte(($urandom_range(0, 3) == 0) ? BYTE_ONE
                                                          : 8'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        guard = 0;
        while ((pending_words.size() != 0 || cmd_busy || awaited_status.size() != 0) &&
               guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (awaited_status.size() != 0) begin
            $display("%0t: %0d status words never arrived", $time, awaited_status.size());
            errors++;
        end
        if (pending_words.size() != 0 || cmd_busy) begin
            $display("%0t: %0d command words never accepted", $time,
                     pending_words.size() + int'(cmd_busy));
            errors++;
        end

        $display("Checked %0d status words for %0d command words: %0d applied, %0d stops,",
                 n_checked, n_accepted, n_applied, n_stops);
        $display("%0d dropped on direction, %0d rejected on speed, %0d unconfirmed",
                 n_dropped, n_rejected, n_unconfirmed);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* motor_command_parser.f */
+incdir+rtl
rtl/mcp_pkg.sv
rtl/mcp_cmd_if.sv
rtl/mcp_status_if.sv
rtl/mcp_input_stage.sv
rtl/mcp_parser_core.sv
rtl/motor_command_parser.sv
tb/sv/motor_command_parser_tb.sv
